/* hw/rtl/vlrs_pkg.sv */
// ----------------------------------------------------------------------------
// vlrs_pkg: shared definitions for the variable-length record stack
// Sizes, operation and status codes, micro-program step addresses, control
// word and sequencer flag structs, and the length clamp.
// ----------------------------------------------------------------------------
package vlrs_pkg;

    // Store geometry
    localparam int BUFFER_BYTES     = 1024;
    localparam int HEADER_BYTES     = 4;
    localparam int MAX_RECORD_BYTES = 8;

    // Fixed field widths
    localparam int OP_W       = 3;
    localparam int DATA_W     = 64;
    localparam int LEN_W      = 4;
    localparam int STATUS_W   = 2;
    localparam int DATA_BYTES = DATA_W / 8;

    // Derived widths
    localparam int ADDR_W  = $clog2(BUFFER_BYTES);
    localparam int PTR_W   = $clog2(BUFFER_BYTES + HEADER_BYTES + MAX_RECORD_BYTES + 1);
    localparam int CNT_W   = $clog2(HEADER_BYTES + MAX_RECORD_BYTES + 1);
    localparam int IDX_W   = $clog2(DATA_BYTES);
    localparam int HDR_W   = 8 * HEADER_BYTES;
    localparam int SHIFT_W = HDR_W + DATA_W;

    // Top pointer value of an empty stack
    localparam logic [PTR_W-1:0] TOP_EMPTY = PTR_W'(BUFFER_BYTES);

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
    localparam logic [OP_W-1:0] OP_POP   = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
    localparam logic [OP_W-1:0] OP_CHECK = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Micro-program step addresses
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] S_IDLE     = 3'd0;
    localparam logic [STEP_W-1:0] S_SETUP    = 3'd1;
    localparam logic [STEP_W-1:0] S_WRITE    = 3'd2;
    localparam logic [STEP_W-1:0] S_READ_HDR = 3'd3;
    localparam logic [STEP_W-1:0] S_TAKE_LEN = 3'd4;
    localparam logic [STEP_W-1:0] S_READ_REC = 3'd5;
    localparam logic [STEP_W-1:0] S_EMIT     = 3'd6;

    // Datapath micro-operations
    typedef enum logic [2:0] {
        UOP_NONE     = 3'd0,
        UOP_SETUP    = 3'd1,
        UOP_WRITE    = 3'd2,
        UOP_READ_HDR = 3'd3,
        UOP_TAKE_LEN = 3'd4,
        UOP_READ_REC = 3'd5
    } t_uop;

    // Next-step selection
    typedef enum logic [1:0] {
        COND_NEXT     = 2'd0,
        COND_ALWAYS   = 2'd1,
        COND_DISPATCH = 2'd2
    } t_cond;

    // One control word of the micro-program
    typedef struct packed {
        logic              accept;  // hold here until a transaction arrives
        logic              loop;    // repeat the micro-op until the count runs out
        logic              emit;    // hold here until the output register is free
        t_uop              uop;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_ctl;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic            in_valid;
        logic            out_busy;
        logic            cnt_zero;
        logic            fail;
        logic [OP_W-1:0] op;
    } t_seq_flags;

    // Lengths above the record limit count as the limit
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
        return (v > LEN_W'(MAX_RECORD_BYTES)) ? LEN_W'(MAX_RECORD_BYTES) : v;
    endfunction

endpackage

/* hw/rtl/vlrs_ram.sv */
// ----------------------------------------------------------------------------
// vlrs_ram: generic simple dual-port RAM
// One write port and one read port, read data registered. No reset.
// ----------------------------------------------------------------------------
module vlrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/vlrs_seq.sv */
// ----------------------------------------------------------------------------
// vlrs_seq: micro-program sequencer
// Step counter, control store and next-step logic with holds, jumps and an
// operation dispatch.
// ----------------------------------------------------------------------------
module vlrs_seq import vlrs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_seq_flags i_flags,
    output t_ctl       o_ctl
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic [STEP_W-1:0] w_disp;
    logic              w_hold;
    t_ctl              w_ctl;

    // Control store
    function automatic t_ctl ctl_rom(input logic [STEP_W-1:0] a);
        t_ctl c;
        c = '{accept: 1'b0, loop: 1'b0, emit: 1'b0, uop: UOP_NONE,
              cond: COND_NEXT, target: S_IDLE};
        case (a)
            S_IDLE: begin
                c.accept = 1'b1;
            end
            S_SETUP: begin
                c.uop  = UOP_SETUP;
                c.cond = COND_DISPATCH;
            end
            S_WRITE: begin
                c.loop   = 1'b1;
                c.uop    = UOP_WRITE;
                c.cond   = COND_ALWAYS;
                c.target = S_EMIT;
            end
            S_READ_HDR: begin
                c.loop = 1'b1;
                c.uop  = UOP_READ_HDR;
            end
            S_TAKE_LEN: begin
                c.uop = UOP_TAKE_LEN;
            end
            S_READ_REC: begin
                c.loop = 1'b1;
                c.uop  = UOP_READ_REC;
            end
            S_EMIT: begin
                c.emit   = 1'b1;
                c.cond   = COND_ALWAYS;
                c.target = S_IDLE;
            end
            default: begin
                c.cond   = COND_ALWAYS;
                c.target = S_IDLE;
            end
        endcase
        return c;
    endfunction

    assign w_ctl = ctl_rom(r_step);
    assign o_ctl = w_ctl;

    // Dispatch on the operation; failed checks go straight to the result
    always_comb begin
        if (i_flags.fail) begin
            w_disp = S_EMIT;
        end else begin
            case (i_flags.op)
                OP_PUSH:          w_disp = S_WRITE;
                OP_POP, OP_PEEK:  w_disp = S_READ_HDR;
                default:          w_disp = S_EMIT;
            endcase
        end
    end

    // Next step
    assign w_hold = (w_ctl.loop && !i_flags.cnt_zero) ||
                    (w_ctl.accept && !i_flags.in_valid) ||
                    (w_ctl.emit && i_flags.out_busy);

    always_comb begin
        if (w_hold) begin
            n_step = r_step;
        end else begin
            case (w_ctl.cond)
                COND_NEXT:     n_step = r_step + STEP_W'(1);
                COND_ALWAYS:   n_step = w_ctl.target;
                COND_DISPATCH: n_step = w_disp;
                default:       n_step = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

/* hw/rtl/variable_length_record_stack.sv */
// ----------------------------------------------------------------------------
// variable_length_record_stack: byte stack of variable-length records
// Datapath, byte store and sequencer of a downward-growing record stack.
// ----------------------------------------------------------------------------
// One transaction is handled at a time and yields one result. Every byte
// goes through a byte-wide port of the store, one per cycle. A push writes
// its L data bytes and the 4-byte header, and besides the write loop passes
// through the setup step, the step that leaves the write loop, the result
// step and the idle step that takes the next transaction. A pop or peek
// returning N bytes reads the header and then the record; each read spends
// one extra step landing the last byte of the registered store read, and
// one step turns the header into the record length. Clear, room check,
// unknown codes and any failed push, pop or peek go from the setup step
// straight to the result step. The result lands in the output register at
// the result step, before the idle step takes the next transaction. A
// stalled output holds the sequencer at its last step until the register
// frees. The store needs no clearing after reset: of the stack state only
// the top pointer is reset, to the empty value, with the read-pending and output-valid flags.
module variable_length_record_stack import vlrs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [OP_W-1:0]     i_op,
    input  logic [DATA_W-1:0]   i_data_in,
    input  logic [LEN_W-1:0]    i_length_bytes,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [DATA_W-1:0]   o_data_out,
    output logic [LEN_W-1:0]    o_stored_length,
    output logic                o_is_empty
);

    t_ctl       w_ctl;
    t_seq_flags w_flags;

    // transaction registers
    logic [OP_W-1:0]     r_op;
    logic [LEN_W-1:0]    r_len;
    logic [SHIFT_W-1:0]  r_shift;
    logic [STATUS_W-1:0] r_status;
    logic [DATA_W-1:0]   r_dout;
    logic [LEN_W-1:0]    r_slen;
    logic [HDR_W-1:0]    r_hdr;

    // pointers and counters
    logic [PTR_W-1:0]    r_top;
    logic [PTR_W-1:0]    n_top;
    logic [PTR_W-1:0]    r_addr;
    logic [CNT_W-1:0]    r_cnt;
    logic [IDX_W-1:0]    r_ridx;

    // read in flight
    logic                r_pend;
    logic [IDX_W-1:0]    r_pidx;
    logic                r_phdr;
    logic                r_poob;

    // output register
    logic                r_ovalid;
    logic [STATUS_W-1:0] r_ostatus;
    logic [DATA_W-1:0]   r_odata;
    logic [LEN_W-1:0]    r_oslen;
    logic                r_oempty;

    logic                w_accept;
    logic                w_out_busy;
    logic                w_emit;
    logic                w_do_op;
    logic                w_we;
    logic                w_rd;
    logic                w_no_room;
    logic                w_empty;
    logic [STATUS_W-1:0] w_chk_status;
    logic                w_fail;
    logic [LEN_W-1:0]    w_hdr_len;
    logic [LEN_W-1:0]    w_take;
    logic [PTR_W-1:0]    w_pop_top;
    logic [7:0]          w_ram_q;
    logic [7:0]          w_rbyte;

    // Sequencer
    assign w_flags = '{in_valid: i_valid, out_busy: w_out_busy, cnt_zero: (r_cnt == '0),
                       fail: w_fail, op: r_op};

    vlrs_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctl   (w_ctl)
    );

    // Handshakes
    assign o_stall    = !w_ctl.accept;
    assign w_accept   = w_ctl.accept && i_valid;
    assign w_out_busy = r_ovalid && i_stall;
    assign w_emit     = w_ctl.emit && !w_out_busy;

    // Loop steps act only while bytes remain
    assign w_do_op = !w_ctl.loop || (r_cnt != '0);
    assign w_we    = (w_ctl.uop == UOP_WRITE) && w_do_op;
    assign w_rd    = ((w_ctl.uop == UOP_READ_HDR) || (w_ctl.uop == UOP_READ_REC)) && w_do_op;

    // Room and empty checks
    assign w_no_room = r_top < (PTR_W'(r_len) + PTR_W'(HEADER_BYTES));
    assign w_empty   = (r_top == TOP_EMPTY);

    always_comb begin
        w_chk_status = ST_OK;
        case (r_op)
            OP_PUSH, OP_CHECK: begin
                if (w_no_room) w_chk_status = ST_FULL;
            end
            OP_POP, OP_PEEK: begin
                if (w_empty) w_chk_status = ST_EMPTY;
            end
            default: ;
        endcase
    end

    assign w_fail = (w_chk_status != ST_OK);

    // Header length, bytes to return and top after a pop
    assign w_hdr_len = (r_hdr > HDR_W'(MAX_RECORD_BYTES)) ? LEN_W'(MAX_RECORD_BYTES)
                                                          : r_hdr[LEN_W-1:0];
    assign w_take    = (r_len < w_hdr_len) ? r_len : w_hdr_len;
    assign w_pop_top = r_top + PTR_W'(HEADER_BYTES) + PTR_W'(w_hdr_len);

    // Byte store
    vlrs_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_addr[ADDR_W-1:0]),
        .i_wdata (r_shift[7:0]),
        .i_raddr (r_addr[ADDR_W-1:0]),
        .o_rdata (w_ram_q)
    );

    // Bytes past the end of the buffer read as zero
    assign w_rbyte = r_poob ? 8'h00 : w_ram_q;

    // Next top pointer
    always_comb begin
        n_top = r_top;
        if (w_ctl.uop == UOP_SETUP) begin
            case (r_op)
                OP_PUSH: begin
                    if (!w_no_room) n_top = r_top - PTR_W'(r_len) - PTR_W'(HEADER_BYTES);
                end
                OP_CLEAR: n_top = TOP_EMPTY;
                default: ;
            endcase
        end else if ((w_ctl.uop == UOP_TAKE_LEN) && (r_op == OP_POP)) begin
            n_top = (w_pop_top > TOP_EMPTY) ? TOP_EMPTY : w_pop_top;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top    <= TOP_EMPTY;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_top  <= n_top;
            r_pend <= w_rd;
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        // take a new transaction
        if (w_accept) begin
            r_op     <= i_op;
            r_len    <= clamp_len(i_length_bytes);
            r_shift  <= {i_data_in, HDR_W'(clamp_len(i_length_bytes))};
            r_status <= ST_OK;
            r_dout   <= '0;
            r_slen   <= '0;
        end

        // micro-operations
        case (w_ctl.uop)
            UOP_SETUP: begin
                r_status <= w_chk_status;
                r_ridx   <= '0;
                if (r_op == OP_PUSH) begin
                    // header and record go out in one ascending run from the new top
                    r_addr <= r_top - PTR_W'(r_len) - PTR_W'(HEADER_BYTES);
                    r_cnt  <= CNT_W'(r_len) + CNT_W'(HEADER_BYTES);
                end else begin
                    r_addr <= r_top;
                    r_cnt  <= CNT_W'(HEADER_BYTES);
                end
            end
            UOP_WRITE: begin
                if (w_do_op) begin
                    r_shift <= r_shift >> 8;
                    r_addr  <= r_addr + PTR_W'(1);
                    r_cnt   <= r_cnt - CNT_W'(1);
                end
            end
            UOP_READ_HDR, UOP_READ_REC: begin
                if (w_do_op) begin
                    r_addr <= r_addr + PTR_W'(1);
                    r_cnt  <= r_cnt - CNT_W'(1);
                    r_ridx <= r_ridx + IDX_W'(1);
                    r_pidx <= r_ridx;
                    r_phdr <= (w_ctl.uop == UOP_READ_HDR);
                    r_poob <= (r_addr >= TOP_EMPTY);
                end
            end
            UOP_TAKE_LEN: begin
                r_slen <= w_hdr_len;
                r_cnt  <= CNT_W'(w_take);
                r_ridx <= '0;
            end
            default: ;
        endcase

        // land the byte read last cycle
        if (r_pend) begin
            for (int b = 0; b < HEADER_BYTES; b++) begin
                if (r_phdr && (r_pidx == IDX_W'(b))) r_hdr[8*b +: 8] <= w_rbyte;
            end
            for (int b = 0; b < DATA_BYTES; b++) begin
                if (!r_phdr && (r_pidx == IDX_W'(b))) r_dout[8*b +: 8] <= w_rbyte;
            end
        end

        // result into the output register
        if (w_emit) begin
            r_ostatus <= r_status;
            r_odata   <= r_dout;
            r_oslen   <= r_slen;
            r_oempty  <= (r_top == TOP_EMPTY);
        end
    end

    assign o_valid         = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_data_out      = r_odata;
    assign o_stored_length = r_oslen;
    assign o_is_empty      = r_oempty;

    // Checks
    a_write_in_buffer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_addr < TOP_EMPTY))
        else $error("store write outside the buffer");

    a_top_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= TOP_EMPTY)
        else $error("top pointer beyond buffer size");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_EMPTY)) |-> o_is_empty)
        else $error("empty status on a non-empty stack");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> ((o_data_out == '0) && (o_stored_length == '0)))
        else $error("failed transaction returned data");

    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> !r_pend)
        else $error("transaction taken while a store read is in flight");

endmodule
